>>> src/nldfa_pkg.sv
// ----------------------------------------------------------------------------
// nldfa_pkg
// Shared types and constants of the line-notation longest-match scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package nldfa_pkg;

  localparam int STATE_W      = 5;
  localparam int COUNT_W      = 13;
  localparam int ACCEPT_W     = 12;
  localparam int POS_W        = 32;
  localparam int CANDIDATE_LIMIT = 4096;

  typedef logic [STATE_W-1:0] state_t;
  typedef logic [7:0]         char_t;

  localparam state_t HEAD_STATE = '0;

  localparam char_t CH_SPACE = 8'h20;
  localparam char_t CH_AMP   = 8'h26;
  localparam char_t CH_DASH  = 8'h2D;
  localparam char_t CH_0     = 8'h30;
  localparam char_t CH_9     = 8'h39;
  localparam char_t CH_A     = 8'h41;
  localparam char_t CH_C     = 8'h43;
  localparam char_t CH_D     = 8'h44;
  localparam char_t CH_J     = 8'h4A;
  localparam char_t CH_L     = 8'h4C;
  localparam char_t CH_T     = 8'h54;
  localparam char_t CH_Z     = 8'h5A;

  // result of one automaton lookup
  typedef struct packed {
    logic   ok;
    state_t nx;
  } trans_t;

  function automatic logic is_accepting(input state_t s);
    return (s == 5'd1) || (s == 5'd7);
  endfunction

endpackage

`default_nettype wire

>>> src/notation_dfa_longest_match_scanner.sv
// ----------------------------------------------------------------------------
// notation_dfa_longest_match_scanner
// Longest-match scanner for a chemical line notation over a byte stream.
// ----------------------------------------------------------------------------
// Takes one byte word per clock while the output side is ready; the input word
// is registered before its result word is. Each byte goes through one input
// register, one automaton lookup from the current state and one from the head
// state, and the result register; candidate state is updated in the same
// cycle, so the sustained rate is one byte per cycle while the output side is
// ready.
// A result word appears only when a match is reported or on the byte marked
// tlast; after the tlast byte all stream counters start again from zero.
// ----------------------------------------------------------------------------
`default_nettype none

module notation_dfa_longest_match_scanner (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,    // allow_carbon_symbol
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // data_byte
  input  wire logic        s_axis_tlast,   // end_of_stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // match_start[31:0], match_length[44:32], scanned_length[57:45],
  // total_matches[89:58], overflow_seen[90], zero fill[95:91]
  output logic [95:0]      m_axis_tdata,
  output logic             m_axis_tuser,   // match_found
  output logic             m_axis_tlast    // stream_done
);

  localparam int CW = nldfa_pkg::COUNT_W;
  localparam int AW = nldfa_pkg::ACCEPT_W;
  localparam int PW = nldfa_pkg::POS_W;

  function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // configuration
  logic allow_c;

  // input register
  logic                in_valid;
  nldfa_pkg::char_t    in_byte;
  logic                in_last;

  // stream state
  nldfa_pkg::state_t   state;
  logic                in_cand;
  logic [PW-1:0]       cand_start;
  logic [CW-1:0]       cand_count;
  logic [AW-1:0]       last_acc;
  logic [PW-1:0]       byte_pos;
  logic [PW-1:0]       tally;
  logic                ovf_flag;

  nldfa_pkg::trans_t   cur_tr, head_tr;
  logic                go;
  logic                adv, ovf, mis_rep, eos_rep, rep, open_cand;
  nldfa_pkg::state_t   state_next;
  logic                in_cand_next;
  logic [PW-1:0]       cand_start_next;
  logic [CW-1:0]       cand_count_next;
  logic [AW-1:0]       last_acc_next;
  logic [PW-1:0]       tally_next;
  logic                ovf_next;
  logic [PW-1:0]       rs;
  logic [CW-1:0]       rl, rsc;

  nldfa_trans u_cur (
    .state   (state),
    .ch      (in_byte),
    .allow_c (allow_c),
    .res     (cur_tr)
  );

  nldfa_trans u_head (
    .state   (nldfa_pkg::HEAD_STATE),
    .ch      (in_byte),
    .allow_c (allow_c),
    .res     (head_tr)
  );

  assign go            = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || go;

  always_comb begin
    ovf     = in_cand && cur_tr.ok && (cand_count >= CW'(nldfa_pkg::CANDIDATE_LIMIT));
    adv     = in_cand && cur_tr.ok && !ovf;
    mis_rep = in_cand && !cur_tr.ok && (last_acc != '0);
    // the byte is tried again from head unless the candidate took it
    open_cand = !adv && head_tr.ok;

    state_next      = nldfa_pkg::HEAD_STATE;
    in_cand_next    = 1'b0;
    cand_start_next = cand_start;
    cand_count_next = cand_count;
    last_acc_next   = last_acc;
    if (adv) begin
      state_next      = cur_tr.nx;
      in_cand_next    = 1'b1;
      cand_count_next = cand_count + 1'b1;
      if (nldfa_pkg::is_accepting(cur_tr.nx)) last_acc_next = cand_count[AW-1:0];
    end else if (open_cand) begin
      state_next      = head_tr.nx;
      in_cand_next    = 1'b1;
      cand_start_next = byte_pos;
      cand_count_next = CW'(1);
      last_acc_next   = '0;
    end

    // flush at end of stream
    eos_rep = in_last && !mis_rep && in_cand_next && (last_acc_next != '0);
    rep     = mis_rep || eos_rep;

    rs  = '0;
    rl  = '0;
    rsc = '0;
    if (mis_rep) begin
      rs  = cand_start;
      rl  = {1'b0, last_acc} + 1'b1;
      rsc = cand_count;
    end else if (eos_rep) begin
      rs  = cand_start_next;
      rl  = {1'b0, last_acc_next} + 1'b1;
      rsc = cand_count_next;
    end

    tally_next = rep ? sat_inc(tally) : tally;
    ovf_next   = ovf_flag || ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      allow_c <= 1'b0;
    end else if (cfg_wr_en) begin
      allow_c <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= nldfa_pkg::HEAD_STATE;
      in_cand    <= 1'b0;
      cand_start <= '0;
      cand_count <= '0;
      last_acc   <= '0;
      byte_pos   <= '0;
      tally      <= '0;
      ovf_flag   <= 1'b0;
    end else if (go) begin
      if (in_last) begin
        state      <= nldfa_pkg::HEAD_STATE;
        in_cand    <= 1'b0;
        cand_start <= '0;
        cand_count <= '0;
        last_acc   <= '0;
        byte_pos   <= '0;
        tally      <= '0;
        ovf_flag   <= 1'b0;
      end else begin
        state      <= state_next;
        in_cand    <= in_cand_next;
        cand_start <= cand_start_next;
        cand_count <= cand_count_next;
        last_acc   <= last_acc_next;
        byte_pos   <= sat_inc(byte_pos);
        tally      <= tally_next;
        ovf_flag   <= ovf_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (go && (rep || in_last)) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && (rep || in_last)) begin
      m_axis_tdata <= {5'd0, ovf_next, tally_next, rsc, rl, rs};
      m_axis_tuser <= rep;
      m_axis_tlast <= in_last;
    end
  end

endmodule

`default_nettype wire

>>> src/nldfa_trans.sv
// ----------------------------------------------------------------------------
// nldfa_trans
// Transition logic of the 27-state notation automaton for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module nldfa_trans (
  input  wire nldfa_pkg::state_t state,
  input  wire nldfa_pkg::char_t  ch,
  input  wire logic              allow_c,
  output nldfa_pkg::trans_t      res
);

  logic up, dig, sym, amp, dash, spc, cj, ct, cl;

  always_comb begin
    up   = (ch >= nldfa_pkg::CH_A) && (ch <= nldfa_pkg::CH_Z);
    dig  = (ch >= nldfa_pkg::CH_0) && (ch <= nldfa_pkg::CH_9);
    amp  = (ch == nldfa_pkg::CH_AMP);
    dash = (ch == nldfa_pkg::CH_DASH);
    spc  = (ch == nldfa_pkg::CH_SPACE);
    cj   = (ch == nldfa_pkg::CH_J);
    ct   = (ch == nldfa_pkg::CH_T);
    cl   = (ch == nldfa_pkg::CH_L);
    // element symbols: capitals except A D J L T, with C only when enabled
    if (ch == nldfa_pkg::CH_C) begin
      sym = allow_c;
    end else begin
      sym = up && (ch != nldfa_pkg::CH_A) && (ch != nldfa_pkg::CH_D) && !cj && !cl && !ct;
    end
  end

  always_comb begin
    res.ok = 1'b1;
    res.nx = nldfa_pkg::HEAD_STATE;
    case (state)
      5'd0: begin
        if (sym || dig) res.nx = 5'd1;
        else if (dash) res.nx = 5'd3;
        else if (cl || ct) res.nx = 5'd6;
        else res.ok = 1'b0;
      end
      5'd1: begin
        if (sym || dig || amp) res.nx = 5'd1;
        else if (dash) res.nx = 5'd3;
        else if (spc) res.nx = 5'd2;
        else res.ok = 1'b0;
      end
      5'd2: begin
        if (up) res.nx = 5'd23;
        else if (amp) res.nx = 5'd0;
        else res.ok = 1'b0;
      end
      5'd3: begin
        if (up) res.nx = 5'd4;
        else if (spc) res.nx = 5'd24;
        else if (amp) res.nx = 5'd26;
        else res.ok = 1'b0;
      end
      5'd4: begin
        if (up) res.nx = 5'd5;
        else res.ok = 1'b0;
      end
      5'd5: begin
        if (dash) res.nx = 5'd1;
        else res.ok = 1'b0;
      end
      5'd6: begin
        if (dig) res.nx = 5'd8;
        else if (spc) res.nx = 5'd9;
        else res.ok = 1'b0;
      end
      5'd7: begin
        if (amp) res.nx = 5'd7;
        else if (spc) res.nx = 5'd2;
        else res.ok = 1'b0;
      end
      5'd8: begin
        if (dig) res.nx = 5'd8;
        else if (cj) res.nx = 5'd7;
        else if (spc) res.nx = 5'd9;
        else if (sym) res.nx = 5'd15;
        else if (dash) res.nx = 5'd16;
        else if (ct || amp) res.nx = 5'd22;
        else res.ok = 1'b0;
      end
      5'd9: begin
        if (up) res.nx = 5'd10;
        else if (dig) res.nx = 5'd11;
        else res.ok = 1'b0;
      end
      5'd10: begin
        if (spc) res.nx = 5'd9;
        else if (dig) res.nx = 5'd8;
        else if (cj) res.nx = 5'd7;
        else if (sym) res.nx = 5'd15;
        else if (dash) res.nx = 5'd16;
        else if (ct || amp) res.nx = 5'd22;
        else res.ok = 1'b0;
      end
      5'd11: begin
        if (dig) res.nx = 5'd11;
        else if (up) res.nx = 5'd12;
        else res.ok = 1'b0;
      end
      5'd12: begin
        if (up || amp) res.nx = 5'd12;
        else if (spc) res.nx = 5'd13;
        else res.ok = 1'b0;
      end
      5'd13: begin
        if (up) res.nx = 5'd14;
        else res.ok = 1'b0;
      end
      5'd14: begin
        if (amp) res.nx = 5'd14;
        else if (cj) res.nx = 5'd7;
        else if (sym) res.nx = 5'd15;
        else if (spc) res.nx = 5'd20;
        else if (ct || dash) res.nx = 5'd22;
        else res.ok = 1'b0;
      end
      5'd15: begin
        if (sym) res.nx = 5'd15;
        else if (dash) res.nx = 5'd16;
        else if (spc) res.nx = 5'd20;
        else if (cj) res.nx = 5'd7;
        else if (ct || amp) res.nx = 5'd22;
        else res.ok = 1'b0;
      end
      5'd16: begin
        if (up) res.nx = 5'd17;
        else res.ok = 1'b0;
      end
      5'd17: begin
        if (up) res.nx = 5'd18;
        else res.ok = 1'b0;
      end
      5'd18: begin
        if (dash) res.nx = 5'd19;
        else res.ok = 1'b0;
      end
      5'd19: begin
        if (sym) res.nx = 5'd15;
        else if (cj) res.nx = 5'd7;
        else if (spc) res.nx = 5'd20;
        else if (ct || amp) res.nx = 5'd22;
        else res.ok = 1'b0;
      end
      5'd20: begin
        if (up) res.nx = 5'd21;
        else res.ok = 1'b0;
      end
      5'd21: begin
        if (sym) res.nx = 5'd15;
        else if (dash) res.nx = 5'd16;
        else res.ok = 1'b0;
      end
      5'd22: begin
        if (cj) res.nx = 5'd7;
        else if (ct || amp) res.nx = 5'd22;
        else res.ok = 1'b0;
      end
      5'd23: begin
        if (amp) res.nx = 5'd23;
        else if (sym || dig) res.nx = 5'd1;
        else if (dash) res.nx = 5'd3;
        else if (spc) res.nx = 5'd2;
        else res.ok = 1'b0;
      end
      5'd24: begin
        if (up) res.nx = 5'd25;
        else res.ok = 1'b0;
      end
      5'd25: begin
        if (amp) res.nx = 5'd25;
        else if (cl || ct) res.nx = 5'd6;
        else res.ok = 1'b0;
      end
      5'd26: begin
        if (spc) res.nx = 5'd24;
        else res.ok = 1'b0;
      end
      default: begin
        res.ok = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the line-notation longest-match scanner.
// ----------------------------------------------------------------------------
// A short stimulus table covers byte extremes, the carbon switch, a head
// state reached inside a candidate, a mismatch on the last byte and a typical
// match; random walks through the automaton follow, then one maximal-length
// match and one overflowing candidate. Every result word is checked field by
// field against a behavioral model of the automaton and counters, or a typed word.
// ----------------------------------------------------------------------------
module tb;
  import nldfa_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  localparam char_t CH_B    = "B";
  localparam char_t CH_BANG = "!";
  localparam char_t CH_1    = "1";

  typedef struct packed {
    logic        found;
    logic [31:0] start;
    logic [12:0] mlen;
    logic [12:0] slen;
    logic [31:0] total;
    logic        done;
    logic        ovf;
  } scan_report_t;

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t    kind;
    char_t        data;     // byte, or register value for ROW_CFG
    logic         last;
    logic         typed;    // use want instead of the model's prediction
    scan_report_t want;
  } stim_row_t;

  localparam scan_report_t NO_REPORT  = '0;
  localparam scan_report_t EMPTY_DONE = '{found: 1'b0, start: '0, mlen: '0, slen: '0,
                                          total: '0, done: 1'b1, ovf: 1'b0};

  localparam int N_ROWS = 26;
  localparam stim_row_t SCRIPT [N_ROWS] = '{
    '{ROW_WORD, 8'h00,    1'b1, 1'b1, EMPTY_DONE},
    '{ROW_WORD, 8'hFF,    1'b1, 1'b1, EMPTY_DONE},
    '{ROW_WORD, CH_C,     1'b1, 1'b1, EMPTY_DONE},  // carbon off: no transition
    '{ROW_WORD, CH_B,     1'b0, 1'b0, NO_REPORT},
    '{ROW_WORD, CH_B,     1'b0, 1'b0, NO_REPORT},
    '{ROW_WORD, CH_BANG,  1'b0, 1'b0, NO_REPORT},
    '{ROW_CFG,  8'h01,    1'b0, 1'b0, NO_REPORT},
    '{ROW_WORD, CH_C,     1'b0, 1'b0, NO_REPORT},
    '{ROW_WORD, CH_C,     1'b1, 1'b0, NO_REPORT},
    // back to the head state mid-candidate, then on
    '{ROW_WORD, CH_1,     1'b0, 1'b0, NO_REPORT},
    '{ROW_WORD, CH_SPACE, 1'b0, 1'b0, NO_REPORT},
    '{ROW_WORD, CH_AMP,   1'b0, 1'b0, NO_REPORT},
    '{ROW_WORD, CH_B,     1'b0, 1'b0, NO_REPORT},
    '{ROW_WORD, CH_BANG,  1'b0, 1'b0, NO_REPORT},
    // mismatch on the last byte reopens a one-byte candidate
    '{ROW_WORD, CH_B,     1'b0, 1'b0, NO_REPORT},
    '{ROW_WORD, CH_B,     1'b0, 1'b0, NO_REPORT},
    '{ROW_WORD, CH_L,     1'b1, 1'b0, NO_REPORT},
    '{ROW_WORD, CH_DASH,  1'b0, 1'b0, NO_REPORT},
    '{ROW_WORD, CH_A,     1'b0, 1'b0, NO_REPORT},
    '{ROW_WORD, CH_Z,     1'b0, 1'b0, NO_REPORT},
    '{ROW_WORD, CH_DASH,  1'b0, 1'b0, NO_REPORT},
    '{ROW_WORD, CH_AMP,   1'b1, 1'b0, NO_REPORT},
    '{ROW_WORD, CH_L,     1'b0, 1'b0, NO_REPORT},
    '{ROW_WORD, CH_0,     1'b0, 1'b0, NO_REPORT},
    '{ROW_WORD, CH_J,     1'b0, 1'b0, NO_REPORT},
    '{ROW_WORD, CH_BANG,  1'b1, 1'b0, NO_REPORT}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;     // data_byte
  logic        s_axis_tlast = 1'b0;   // end_of_stream
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // match_start, match_length, scanned_length, total_matches, overflow_seen
  logic [95:0] m_axis_tdata;
  logic        m_axis_tuser;          // match_found
  logic        m_axis_tlast;          // stream_done

  notation_dfa_longest_match_scanner dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk = ~clk;

  // model of the scanner
  logic        carbon_ok = 1'b0;
  state_t      dfa_state = HEAD_STATE;
  logic        cand_open = 1'b0;
  logic [31:0] cand_start = '0;
  logic [12:0] cand_count = '0;
  logic [11:0] last_accept = '0;
  logic [31:0] byte_pos = '0;
  logic [31:0] match_tally = '0;
  logic        overflow_hit = 1'b0;

  scan_report_t pending_reports[$];
  scan_report_t want;
  int           errors = 0;
  bit           calm = 1'b0;
  bit           hold_out = 1'b0;
  int unsigned  cycle_count = 0;

  function automatic logic is_elem(input char_t c);
    if (c == CH_C) return carbon_ok;
    return c >= CH_A && c <= CH_Z && c != CH_A && c != CH_D && c != CH_J &&
           c != CH_L && c != CH_T;
  endfunction

  function automatic trans_t step_state(input state_t s, input char_t c);
    trans_t r;
    logic sy, up, dg;
    sy = is_elem(c);
    up = c >= CH_A && c <= CH_Z;
    dg = c >= CH_0 && c <= CH_9;
    r.ok = 1'b1;
    r.nx = HEAD_STATE;
    case (s)
      5'd0: begin
        if (sy || dg) r.nx = 5'd1;
        else if (c == CH_DASH) r.nx = 5'd3;
        else if (c == CH_L || c == CH_T) r.nx = 5'd6;
        else r.ok = 1'b0;
      end
      5'd1: begin
        if (sy || dg || c == CH_AMP) r.nx = 5'd1;
        else if (c == CH_DASH) r.nx = 5'd3;
        else if (c == CH_SPACE) r.nx = 5'd2;
        else r.ok = 1'b0;
      end
      5'd2: begin
        if (up) r.nx = 5'd23;
        else if (c == CH_AMP) r.nx = 5'd0;
        else r.ok = 1'b0;
      end
      5'd3: begin
        if (up) r.nx = 5'd4;
        else if (c == CH_SPACE) r.nx = 5'd24;
        else if (c == CH_AMP) r.nx = 5'd26;
        else r.ok = 1'b0;
      end
      5'd4: begin
        if (up) r.nx = 5'd5;
        else r.ok = 1'b0;
      end
      5'd5: begin
        if (c == CH_DASH) r.nx = 5'd1;
        else r.ok = 1'b0;
      end
      5'd6: begin
        if (dg) r.nx = 5'd8;
        else if (c == CH_SPACE) r.nx = 5'd9;
        else r.ok = 1'b0;
      end
      5'd7: begin
        if (c == CH_AMP) r.nx = 5'd7;
        else if (c == CH_SPACE) r.nx = 5'd2;
        else r.ok = 1'b0;
      end
      5'd8: begin
        if (dg) r.nx = 5'd8;
        else if (c == CH_J) r.nx = 5'd7;
        else if (c == CH_SPACE) r.nx = 5'd9;
        else if (sy) r.nx = 5'd15;
        else if (c == CH_DASH) r.nx = 5'd16;
        else if (c == CH_T || c == CH_AMP) r.nx = 5'd22;
        else r.ok = 1'b0;
      end
      5'd9: begin
        if (up) r.nx = 5'd10;
        else if (dg) r.nx = 5'd11;
        else r.ok = 1'b0;
      end
      5'd10: begin
        if (c == CH_SPACE) r.nx = 5'd9;
        else if (dg) r.nx = 5'd8;
        else if (c == CH_J) r.nx = 5'd7;
        else if (sy) r.nx = 5'd15;
        else if (c == CH_DASH) r.nx = 5'd16;
        else if (c == CH_T || c == CH_AMP) r.nx = 5'd22;
        else r.ok = 1'b0;
      end
      5'd11: begin
        if (dg) r.nx = 5'd11;
        else if (up) r.nx = 5'd12;
        else r.ok = 1'b0;
      end
      5'd12: begin
        if (up || c == CH_AMP) r.nx = 5'd12;
        else if (c == CH_SPACE) r.nx = 5'd13;
        else r.ok = 1'b0;
      end
      5'd13: begin
        if (up) r.nx = 5'd14;
        else r.ok = 1'b0;
      end
      5'd14: begin
        if (c == CH_AMP) r.nx = 5'd14;
        else if (c == CH_J) r.nx = 5'd7;
        else if (sy) r.nx = 5'd15;
        else if (c == CH_SPACE) r.nx = 5'd20;
        else if (c == CH_T || c == CH_DASH) r.nx = 5'd22;
        else r.ok = 1'b0;
      end
      5'd15: begin
        if (sy) r.nx = 5'd15;
        else if (c == CH_DASH) r.nx = 5'd16;
        else if (c == CH_SPACE) r.nx = 5'd20;
        else if (c == CH_J) r.nx = 5'd7;
        else if (c == CH_T || c == CH_AMP) r.nx = 5'd22;
        else r.ok = 1'b0;
      end
      5'd16: begin
        if (up) r.nx = 5'd17;
        else r.ok = 1'b0;
      end
      5'd17: begin
        if (up) r.nx = 5'd18;
        else r.ok = 1'b0;
      end
      5'd18: begin
        if (c == CH_DASH) r.nx = 5'd19;
        else r.ok = 1'b0;
      end
      5'd19: begin
        if (sy) r.nx = 5'd15;
        else if (c == CH_J) r.nx = 5'd7;
        else if (c == CH_SPACE) r.nx = 5'd20;
        else if (c == CH_T || c == CH_AMP) r.nx = 5'd22;
        else r.ok = 1'b0;
      end
      5'd20: begin
        if (up) r.nx = 5'd21;
        else r.ok = 1'b0;
      end
      5'd21: begin
        if (sy) r.nx = 5'd15;
        else if (c == CH_DASH) r.nx = 5'd16;
        else r.ok = 1'b0;
      end
      5'd22: begin
        if (c == CH_J) r.nx = 5'd7;
        else if (c == CH_T || c == CH_AMP) r.nx = 5'd22;
        else r.ok = 1'b0;
      end
      5'd23: begin
        if (c == CH_AMP) r.nx = 5'd23;
        else if (sy || dg) r.nx = 5'd1;
        else if (c == CH_DASH) r.nx = 5'd3;
        else if (c == CH_SPACE) r.nx = 5'd2;
        else r.ok = 1'b0;
      end
      5'd24: begin
        if (up) r.nx = 5'd25;
        else r.ok = 1'b0;
      end
      5'd25: begin
        if (c == CH_AMP) r.nx = 5'd25;
        else if (c == CH_L || c == CH_T) r.nx = 5'd6;
        else r.ok = 1'b0;
      end
      5'd26: begin
        if (c == CH_SPACE) r.nx = 5'd24;
        else r.ok = 1'b0;
      end
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

  // advance the model by one accepted byte; has is set when a word is due
  task automatic scan_byte(input char_t c, input logic eos, output logic has,
                           output scan_report_t r);
    trans_t t;
    logic   consumed;
    r = '0;
    consumed = 1'b0;
    if (cand_open) begin
      t = step_state(dfa_state, c);
      if (!t.ok) begin
        if (last_accept != 0) begin
          r.found = 1'b1;
          r.start = cand_start;
          r.mlen  = {1'b0, last_accept} + 13'd1;
          r.slen  = cand_count;
        end
        cand_open = 1'b0;
        dfa_state = HEAD_STATE;
      end else if (cand_count >= CANDIDATE_LIMIT) begin
        overflow_hit = 1'b1;
        cand_open    = 1'b0;
        dfa_state    = HEAD_STATE;
      end else begin
        dfa_state = t.nx;
        if (t.nx == 5'd1 || t.nx == 5'd7) last_accept = cand_count[11:0];
        cand_count = cand_count + 13'd1;
        consumed   = 1'b1;
      end
    end
    if (!consumed) begin
      t = step_state(HEAD_STATE, c);
      if (t.ok) begin
        cand_open   = 1'b1;
        cand_start  = byte_pos;
        cand_count  = 13'd1;
        last_accept = '0;
        dfa_state   = t.nx;
      end
    end
    if (byte_pos != '1) byte_pos = byte_pos + 32'd1;
    // flush on the last byte unless its own mismatch already reported
    if (eos && !r.found && cand_open && last_accept != 0) begin
      r.found = 1'b1;
      r.start = cand_start;
      r.mlen  = {1'b0, last_accept} + 13'd1;
      r.slen  = cand_count;
    end
    if (r.found && match_tally != '1) match_tally = match_tally + 32'd1;
    has     = r.found || eos;
    r.total = match_tally;
    r.done  = eos;
    r.ovf   = overflow_hit;
    if (eos) begin
      dfa_state    = HEAD_STATE;
      cand_open    = 1'b0;
      cand_start   = '0;
      cand_count   = '0;
      last_accept  = '0;
      byte_pos     = '0;
      match_tally  = '0;
      overflow_hit = 1'b0;
    end
  endtask

  task automatic send_word(input char_t c, input logic last, input logic typed = 1'b0,
                           input scan_report_t typed_want = '0);
    logic         has;
    scan_report_t r;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    scan_byte(c, last, has, r);
    if (typed) pending_reports.push_back(typed_want);
    else if (has) pending_reports.push_back(r);
    if (!calm && $urandom_range(99) < 20) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_carbon(input logic v);
    s_axis_tvalid <= 1'b0;
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    carbon_ok = v;
  endtask

  function automatic char_t notation_char();
    case ($urandom_range(9))
      0, 1, 2: return char_t'($urandom_range(CH_A, CH_Z));
      3, 4:    return char_t'($urandom_range(CH_0, CH_9));
      5:       return CH_AMP;
      6:       return CH_DASH;
      7:       return CH_SPACE;
      8:       return CH_J;
      default: return $urandom_range(1) ? CH_L : CH_T;
    endcase
  endfunction

  // mostly follow a live transition so candidates grow deep
  function automatic char_t pick_next();
    char_t  c;
    trans_t t;
    int     roll;
    roll = $urandom_range(99);
    if (roll < 6) return char_t'($urandom_range(255));
    c = notation_char();
    if (roll < 20) return c;
    for (int k = 0; k < 12; k++) begin
      t = step_state(cand_open ? dfa_state : HEAD_STATE, c);
      if (t.ok) return c;
      c = notation_char();
    end
    return c;
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_word(pick_next(), $urandom_range(39) == 0);
  endtask

  task automatic send_run(input char_t c, input int n);
    for (int i = 0; i < n; i++) send_word(c, 1'b0);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_out) begin
        hold_out = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 26);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_reports.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        want = pending_reports.pop_front();
        check_field("match_found", want.found, m_axis_tuser);
        check_field("match_start", want.start, m_axis_tdata[31:0]);
        check_field("match_length", want.mlen, m_axis_tdata[44:32]);
        check_field("scanned_length", want.slen, m_axis_tdata[57:45]);
        check_field("total_matches", want.total, m_axis_tdata[89:58]);
        check_field("stream_done", want.done, m_axis_tlast);
        check_field("overflow_seen", want.ovf, m_axis_tdata[90]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      if (SCRIPT[i].kind == ROW_CFG) set_carbon(SCRIPT[i].data[0]);
      else send_word(SCRIPT[i].data, SCRIPT[i].last, SCRIPT[i].typed, SCRIPT[i].want);
    end

    send_random(300);
    // receiver holds off while short matches keep coming
    hold_out = 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_word(CH_B, 1'b0);
      send_word(CH_B, 1'b0);
      send_word(CH_BANG, 1'b0);
    end
    send_random(100);

    set_carbon(1'b0);
    calm = 1'b1;
    send_random(150);
    calm = 1'b0;
    send_random(250);

    // longest reportable match, then a candidate that overruns the limit
    send_word(CH_BANG, 1'b1);
    send_run(CH_B, CANDIDATE_LIMIT);
    send_word(CH_BANG, 1'b0);
    send_word(CH_BANG, 1'b1);
    send_run(CH_B, CANDIDATE_LIMIT + 2);
    send_word(CH_BANG, 1'b1);

    set_carbon(1'b1);
    send_random(100);
    s_axis_tvalid <= 1'b0;
    drain_results();
    send_random(100);

    s_axis_tvalid <= 1'b0;
    drain_results();
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
